[design/nssm_pkg.sv]
// shared types and constants of the nfa state-set matcher
package nssm_pkg;

  // input item action codes
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_CHAR  = 2'd2
  } action_t;

  // configuration register indexes
  localparam logic [1:0] REG_INITIAL_MASK = 2'd0;
  localparam logic [1:0] REG_FINAL_MASK   = 2'd1;

  // symbol that marks an epsilon edge
  localparam logic [6:0] EPS_SYMBOL = 7'd0;

  // widest table address (alphabet of up to 256 symbols)
  localparam int ADDR_W_MAX = 8;
  // compare widths that hold the largest state count and alphabet size
  localparam int STATE_CMP_W = 7;
  localparam int SYM_CMP_W   = 9;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_STEP,
    ST_CLOSE,
    ST_DONE
  } state_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic                  rd_en;
    logic                  ld_wr;
    logic                  clr_wr;
    logic                  use_eps;
    logic [ADDR_W_MAX-1:0] addr;
  } cell_ctl_t;

endpackage

[design/nfa_state_set_matcher_unit.sv]
// top level of the nfa state-set matcher: sequencer, registers and the row of state cells
//
// The block runs an NFA of NUM_STATES states over symbols below ALPHABET_SIZE. A load item
// (action 0) ORs target_mask into the edge row of (from_state, symbol), read when the item
// is taken and written in ST_LOAD_WR; it gives no result. A begin item (action 1) closes
// initial_mask over epsilon edges (symbol 0); a character item (action 2) ORs the rows of
// all active states for that symbol and then closes the union. Each begin or character
// item returns one result: active_set and accept (active_set meets final_mask). Every
// state is a cell with its own edge memory and a register copy of its epsilon row; one or
// chain through the row of cells forms a successor set per cycle. A begin item runs
// closure rounds in ST_CLOSE, a character item ST_STEP and then closure rounds, until a
// round adds no state; the result is then given in ST_DONE. After reset a clearing pass
// over all ALPHABET_SIZE addresses empties all edge memories; no item is taken during it,
// while configuration writes are taken at any time outside reset. The next item is taken
// while a result still waits in the output register.
module nfa_state_set_matcher_unit #(
  parameter int NUM_STATES    = 16,
  parameter int ALPHABET_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  from_state,
  input  logic [6:0]  symbol,
  input  logic [15:0] target_mask,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] active_set,
  output logic        accept,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import nssm_pkg::*;

  localparam int NS = NUM_STATES;
  localparam int AW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  // common width of port masks and state sets
  localparam int WW = (NS > 16) ? NS : 16;

  state_t state, state_next;

  // registers
  logic [15:0]          initial_mask;
  logic [15:0]          final_mask;
  logic [NS-1:0]        current_states;
  logic [NS-1:0]        set_reg;
  logic [NS-1:0]        tgt_q;
  logic [3:0]           from_q;
  logic [6:0]           sym_q;
  logic                 sym_ok_q;
  logic [AW-1:0]        clr_addr;

  // handshakes
  logic                 in_fire;
  logic                 deliver;

  // widened masks
  logic [WW-1:0]        tgt_w;
  logic [WW-1:0]        init_w;
  logic [WW-1:0]        final_w;
  logic [WW-1:0]        set_w;
  logic [NS-1:0]        final_ns;

  // range checks on the input item
  logic                 sym_ok_in;
  logic                 from_ok_in;
  logic                 clr_last;

  cell_ctl_t            ctl;
  logic [NS-1:0]        chain [NS+1];
  logic [NS-1:0]        chain_out;

  // register writes are dropped while reset is held
  assign cfg_ready = !rst;

  assign in_fire    = in_valid && in_ready;
  assign sym_ok_in  = SYM_CMP_W'(symbol) < SYM_CMP_W'(ALPHABET_SIZE);
  assign from_ok_in = STATE_CMP_W'(from_state) < STATE_CMP_W'(NS);
  assign clr_last   = clr_addr == AW'(ALPHABET_SIZE - 1);

  // mask bits at or above NUM_STATES are dropped
  assign tgt_w    = WW'(target_mask);
  assign init_w   = WW'(initial_mask);
  assign final_w  = WW'(final_mask);
  assign final_ns = final_w[NS-1:0];
  assign set_w    = WW'(set_reg);

  // ---------------------------------------------------------------------------
  // row of state cells; the or chain starts from the set itself while closing
  // ---------------------------------------------------------------------------
  assign chain[0]  = (state == ST_CLOSE) ? set_reg : '0;
  assign chain_out = chain[NS];

  for (genvar q = 0; q < NS; q++) begin : g_cell
    nssm_cell #(
      .NUM_STATES    (NS),
      .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .sel     (STATE_CMP_W'(from_q) == STATE_CMP_W'(q)),
      .active  (set_reg[q]),
      .tgt     (tgt_q),
      .acc_in  (chain[q]),
      .acc_out (chain[q+1])
    );
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (action)
            ACT_LOAD: begin
              // a load outside the table changes nothing
              if (sym_ok_in && from_ok_in) state_next = ST_LOAD_WR;
            end
            ACT_BEGIN: state_next = ST_CLOSE;
            ACT_CHAR:  state_next = ST_STEP;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_WR: state_next = ST_IDLE;
      ST_STEP:    state_next = ST_CLOSE;
      ST_CLOSE: begin
        // fixpoint reached when a round adds nothing
        if (chain_out == set_reg) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs of the sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready    = (state == ST_IDLE);
    deliver     = (state == ST_DONE) && (!out_valid || out_ready);
    ctl.rd_en   = in_valid && (state == ST_IDLE) && sym_ok_in &&
                  ((action == ACT_LOAD) || (action == ACT_CHAR));
    ctl.ld_wr   = (state == ST_LOAD_WR);
    ctl.clr_wr  = (state == ST_CLEAR);
    ctl.use_eps = (state == ST_CLOSE);
    case (state)
      ST_CLEAR:   ctl.addr = ADDR_W_MAX'(clr_addr);
      ST_LOAD_WR: ctl.addr = ADDR_W_MAX'(sym_q);
      default:    ctl.addr = ADDR_W_MAX'(symbol);
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      current_states <= '0;
      initial_mask   <= '0;
      final_mask     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (deliver) begin
        out_valid      <= 1'b1;
        current_states <= set_reg;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INITIAL_MASK: initial_mask <= cfg_data;
          REG_FINAL_MASK:   final_mask   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          from_q   <= from_state;
          sym_q    <= symbol;
          sym_ok_q <= sym_ok_in;
          tgt_q    <= tgt_w[NS-1:0];
          if (action == ACT_BEGIN) begin
            set_reg <= init_w[NS-1:0];
          end else begin
            set_reg <= current_states;
          end
        end
      end
      // successors of the active states; a symbol outside the table has none
      ST_STEP:  set_reg <= sym_ok_q ? chain_out : '0;
      ST_CLOSE: set_reg <= chain_out;
      default: ;
    endcase
    if (deliver) begin
      active_set <= set_w[15:0];
      accept     <= |(set_reg & final_ns);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> state == ST_CLEAR)
    else $error("clearing pass not started after reset");

  // a closure round never drops a state
  a_close_grows: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLOSE |=> (set_reg & $past(set_reg)) == $past(set_reg))
    else $error("closure round dropped a state");

  // a result appears only at the end of a begin or character item
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done step");

  // no item is taken before the edge memories are cleared
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_fire)
    else $error("item taken during clearing pass");

endmodule

[design/nssm_cell.sv]
// one nfa state: its edge rows, its epsilon row and its link in the or chain
module nssm_cell #(
  parameter int NUM_STATES    = 16,
  parameter int ALPHABET_SIZE = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nssm_pkg::cell_ctl_t   ctl,
  input  logic                  sel,
  input  logic                  active,
  input  logic [NUM_STATES-1:0] tgt,
  input  logic [NUM_STATES-1:0] acc_in,
  output logic [NUM_STATES-1:0] acc_out
);
  import nssm_pkg::*;

  localparam int AW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

  logic [NUM_STATES-1:0] mem [ALPHABET_SIZE];
  logic [NUM_STATES-1:0] rd_data;
  logic [NUM_STATES-1:0] eps_row;
  logic [NUM_STATES-1:0] row;
  logic [NUM_STATES-1:0] wr_data;
  logic [AW-1:0]         addr;
  logic                  wr_mine;

  assign addr    = ctl.addr[AW-1:0];
  assign wr_mine = ctl.ld_wr && sel;
  assign wr_data = rd_data | tgt;

  always_ff @(posedge clk) begin
    if (ctl.clr_wr) begin
      mem[addr] <= '0;
    end else if (wr_mine) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // copy of the epsilon row, read every closure round
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_row <= '0;
    end else if (wr_mine && (ctl.addr == ADDR_W_MAX'(EPS_SYMBOL))) begin
      eps_row <= wr_data;
    end
  end

  assign row     = ctl.use_eps ? eps_row : rd_data;
  assign acc_out = acc_in | (active ? row : '0);

endmodule

[test/nfa_state_set_matcher_unit_test.sv]
// testbench of the nfa state-set matcher: directed table, then random strings checked by a predictor
module nfa_state_set_matcher_unit_test;
  import nssm_pkg::*;

  localparam int N_STATES  = 16;
  localparam int N_SYMBOLS = 128;
  // the block ignores this action code and gives no result
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // generous bound: slowest item plus long output stalls and input gaps
  localparam int CYCLE_LIMIT     = 600000;
  // cycles to let a trailing load item retire before a register write or the end
  localparam int DRAIN_CYCLES    = 40;
  // long receiver hold-off, so the output register fills and in_ready drops
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 530;
  localparam int MAX_REPORTS     = 40;

  // directed rows: plain item, item with a hand-written result, register setting
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  // for ROW_CFG, data is the initial mask and aux the final mask;
  // for ROW_TYPED, aux and want_acc hold the result read off by hand
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  code;
    logic [3:0]  src;
    logic [6:0]  sym;
    logic [15:0] data;
    logic [15:0] aux;
    logic        want_acc;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] states;
    logic        acc;
  } match_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [3:0]  from_state;
  logic [6:0]  symbol;
  logic [15:0] target_mask;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] active_set;
  logic        accept;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // predictor state: edge rows per (state, symbol), active set, both registers
  logic [15:0] edge_rows [N_STATES][N_SYMBOLS];
  logic [15:0] live_states;
  logic [15:0] start_states;
  logic [15:0] accept_states;

  match_result_t pending_results[$];
  plan_row_t     script[$];
  logic [6:0]    sym_pool[4];

  int tx_gap_pct;
  int rx_stall_pct;
  int holds_asked;
  int holds_done;
  int mismatches;
  int cycle_count = 0;

  nfa_state_set_matcher_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .from_state  (from_state),
    .symbol      (symbol),
    .target_mask (target_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .active_set  (active_set),
    .accept      (accept),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run guard: a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // fixpoint over epsilon rows: keep adding until no new state appears
  function automatic logic [15:0] eps_closure(input logic [15:0] seed);
    logic [15:0] grown;
    logic [15:0] prev;
    grown = seed;
    do begin
      prev = grown;
      for (int q = 0; q < N_STATES; q++)
        if (grown[q]) grown = grown | edge_rows[q][EPS_SYMBOL];
    end while (grown != prev);
    return grown;
  endfunction

  // applies one item to the predictor; returns 1 when the item yields a result
  function automatic bit advance_matcher(input logic [1:0] act, input logic [3:0] src,
                                         input logic [6:0] sym, input logic [15:0] targets,
                                         output match_result_t res);
    logic [15:0] next;
    next = '0;
    res  = '0;
    case (act)
      ACT_LOAD: begin
        edge_rows[src][sym] = edge_rows[src][sym] | targets;
        return 1'b0;
      end
      ACT_BEGIN: begin
        live_states = eps_closure(start_states);
      end
      ACT_CHAR: begin
        // character 0 reads the epsilon rows like any other symbol
        for (int q = 0; q < N_STATES; q++)
          if (live_states[q]) next = next | edge_rows[q][sym];
        live_states = eps_closure(next);
      end
      default: begin
        return 1'b0;
      end
    endcase
    res.states = live_states;
    res.acc    = |(live_states & accept_states);
    return 1'b1;
  endfunction

  // offers one item, holds it until taken, then records what it should produce
  task automatic offer_item(input logic [1:0] act, input logic [3:0] src, input logic [6:0] sym,
                            input logic [15:0] targets, input bit typed,
                            input match_result_t typed_res);
    match_result_t res;
    if ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    from_state  <= src;
    symbol      <= sym;
    target_mask <= targets;
    do @(posedge clk); while (!in_ready);
    if (advance_matcher(act, src, sym, targets, res))
      pending_results.push_back(typed ? typed_res : res);
  endtask

  // registers change only with the block idle: drain results, let a load retire, then write
  task automatic reconfigure(input logic [15:0] init_mask, input logic [15:0] fin_mask);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_INITIAL_MASK;
    cfg_data  <= init_mask;
    do @(posedge clk); while (!cfg_ready);
    start_states = init_mask;
    cfg_index <= REG_FINAL_MASK;
    cfg_data  <= fin_mask;
    do @(posedge clk); while (!cfg_ready);
    accept_states = fin_mask;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [1:0] code, input logic [3:0] src,
                         input logic [6:0] sym, input logic [15:0] data,
                         input logic [15:0] aux, input logic want_acc);
    plan_row_t r;
    r = {kind, code, src, sym, data, aux, want_acc};
    script.push_back(r);
  endtask

  // mostly well-formed traffic: sparse edge loads over a small alphabet, begins, strings of
  // characters from that alphabet; a little noise on top
  task automatic random_item();
    int            pick;
    logic [6:0]    sym;
    logic [15:0]   tgt;
    match_result_t none;
    none = '0;
    pick = $urandom_range(99);
    sym  = sym_pool[$urandom_range(3)];
    tgt  = 16'd1 << $urandom_range(15);
    if ($urandom_range(3) == 0) tgt = tgt | (16'd1 << $urandom_range(15));
    if (pick < 3) begin
      offer_item(ACT_UNUSED, 4'($urandom), 7'($urandom), 16'($urandom), 1'b0, none);
    end else if (pick < 5) begin
      // dense load anywhere in the table
      offer_item(ACT_LOAD, 4'($urandom), 7'($urandom), 16'($urandom), 1'b0, none);
    end else if (pick < 30) begin
      if ($urandom_range(15) == 0) sym = EPS_SYMBOL;
      offer_item(ACT_LOAD, 4'($urandom_range(15)), sym, tgt, 1'b0, none);
    end else if (pick < 38) begin
      offer_item(ACT_BEGIN, 4'($urandom), 7'($urandom), 16'($urandom), 1'b0, none);
    end else begin
      if ($urandom_range(19) == 0) sym = $urandom_range(1) ? EPS_SYMBOL : 7'($urandom);
      offer_item(ACT_CHAR, 4'($urandom), sym, 16'($urandom), 1'b0, none);
    end
  endtask

  // result side: random stalls, with an occasional long hold-off counted here
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done = holds_asked;
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // every result taken is compared with the oldest expectation
  always @(posedge clk) begin : check_results
    match_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected, active_set", active_set, '0);
      end else begin
        want = pending_results.pop_front();
        if (active_set !== want.states)
          report_mismatch("active_set", active_set, want.states);
        if (accept !== want.acc)
          report_mismatch("accept", {15'd0, accept}, {15'd0, want.acc});
      end
    end
  end

  initial begin : stimulus
    plan_row_t     r;
    match_result_t typed_res;
    logic [15:0]   init_mask;
    logic [15:0]   fin_mask;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_LOAD;
    from_state   <= '0;
    symbol       <= '0;
    target_mask  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_INITIAL_MASK;
    cfg_data     <= '0;
    tx_gap_pct   = 13;
    rx_stall_pct = 68;
    holds_asked  = 0;
    holds_done   = 0;
    mismatches   = 0;

    for (int q = 0; q < N_STATES; q++)
      for (int s = 0; s < N_SYMBOLS; s++)
        edge_rows[q][s] = '0;
    live_states   = '0;
    start_states  = '0;
    accept_states = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // character before any begin, and begin with no initial states: both empty
    add_row(ROW_TYPED, ACT_CHAR,   4'd0,  7'd5,       16'h0000, 16'h0000, 1'b0);
    add_row(ROW_TYPED, ACT_BEGIN,  4'd0,  7'd0,       16'h0000, 16'h0000, 1'b0);
    // unused action leaves everything alone
    add_row(ROW_ITEM,  ACT_UNUSED, 4'd15, 7'd127,     16'hffff, 16'h0000, 1'b0);
    add_row(ROW_CFG,   2'd0,       4'd0,  7'd0,       16'h0001, 16'h8000, 1'b0);
    // epsilon chain 0 -> 1 -> 2
    add_row(ROW_ITEM,  ACT_LOAD,   4'd0,  EPS_SYMBOL, 16'h0002, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_LOAD,   4'd1,  EPS_SYMBOL, 16'h0004, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_BEGIN,  4'd0,  7'd0,       16'h0000, 16'h0000, 1'b0);
    // highest symbol, highest state, full target mask
    add_row(ROW_ITEM,  ACT_LOAD,   4'd2,  7'd127,     16'h8000, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_LOAD,   4'd15, 7'd127,     16'hffff, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_CHAR,   4'd0,  7'd127,     16'h0000, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_CHAR,   4'd0,  7'd127,     16'h0000, 16'h0000, 1'b0);
    // consuming character 0 walks the epsilon rows once, then closes
    add_row(ROW_ITEM,  ACT_CHAR,   4'd0,  EPS_SYMBOL, 16'h0000, 16'h0000, 1'b0);
    // nothing loaded on symbol 64: set goes empty
    add_row(ROW_TYPED, ACT_CHAR,   4'd0,  7'd64,      16'h0000, 16'h0000, 1'b0);
    // epsilon loop back from the top state, and an empty load
    add_row(ROW_ITEM,  ACT_LOAD,   4'd15, EPS_SYMBOL, 16'h0001, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_LOAD,   4'd3,  EPS_SYMBOL, 16'h0000, 16'h0000, 1'b0);
    // all states initial, none final
    add_row(ROW_CFG,   2'd0,       4'd0,  7'd0,       16'hffff, 16'h0000, 1'b0);
    add_row(ROW_TYPED, ACT_BEGIN,  4'd0,  7'd0,       16'h0000, 16'hffff, 1'b0);
    add_row(ROW_CFG,   2'd0,       4'd0,  7'd0,       16'h8000, 16'hffff, 1'b0);
    add_row(ROW_ITEM,  ACT_BEGIN,  4'd0,  7'd0,       16'h0000, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_CHAR,   4'd0,  7'd127,     16'h0000, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_LOAD,   4'd7,  7'h55,      16'haaaa, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_LOAD,   4'd8,  7'h2a,      16'h5555, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_CHAR,   4'd0,  7'h55,      16'h0000, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_CHAR,   4'd0,  7'h2a,      16'h0000, 16'h0000, 1'b0);
    add_row(ROW_ITEM,  ACT_UNUSED, 4'd0,  7'd0,       16'h0000, 16'h0000, 1'b0);

    foreach (script[i]) begin
      r = script[i];
      typed_res.states = r.aux;
      typed_res.acc    = r.want_acc;
      if (r.kind == ROW_CFG)
        reconfigure(r.data, r.aux);
      else
        offer_item(r.code, r.src, r.sym, r.data, r.kind == ROW_TYPED, typed_res);
    end

    // three idling regimes: slow receiver, slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      tx_gap_pct   = (phase == 0) ? 13 : (phase == 1) ? 68 : 0;
      rx_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 13 : 0;
      for (int s = 0; s < 4; s++)
        sym_pool[s] = 7'($urandom_range(1, 127));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // new settings at the start and halfway; each one first drains the block fully
        if (n == 0 || n == ITEMS_PER_PHASE / 2) begin
          init_mask = 16'd1 << $urandom_range(15);
          if ($urandom_range(1)) init_mask = init_mask | (16'd1 << $urandom_range(15));
          fin_mask = $urandom_range(1) ? 16'($urandom) : (16'd1 << $urandom_range(15));
          reconfigure(init_mask, fin_mask);
        end
        if (n == 100 && phase != 1) holds_asked++;
        random_item();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
design/nssm_pkg.sv
design/nssm_cell.sv
design/nfa_state_set_matcher_unit.sv
test/nfa_state_set_matcher_unit_test.sv
